// ===== hw/rtl/assert_macros.svh =====
// assert_macros.svh: assertion macros shared by the RTL files.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every clock, disabled in reset
`define ASSERT_IMP(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

// ===== hw/rtl/gsbc_pkg.sv =====
// gsbc_pkg: constants and types for the grid sample block cache.
// No dependencies.
package gsbc_pkg;
    localparam logic [1:0] ST_SAMPLE = 2'd0;
    localparam logic [1:0] ST_FILL_REQ = 2'd1;
    localparam logic [1:0] ST_NO_SAMPLE = 2'd2;
    localparam logic [1:0] ST_ORDER = 2'd3;
    localparam logic [63:0] SLOT_HASH_MUL = 64'd1315423911;
    localparam logic [2:0] CFG_ORIGIN_X = 3'd0;
    localparam logic [2:0] CFG_ORIGIN_Y = 3'd1;
    localparam logic [2:0] CFG_ORIGIN_Z = 3'd2;
    localparam logic [2:0] CFG_SPACING = 3'd3;
    localparam logic [2:0] CFG_SIZE_X = 3'd4;
    localparam logic [2:0] CFG_SIZE_Y = 3'd5;
    localparam logic [2:0] CFG_SIZE_Z = 3'd6;
    localparam logic [2:0] CFG_DEF_MAT = 3'd7;

    // divider handshake
    typedef struct packed {
        logic start;
        logic [64:0] dividend;
        logic [62:0] divisor;
    } div_req_t;
    typedef struct packed {
        logic done;
        logic [64:0] quotient;
        logic rem_zero;
    } div_rsp_t;
endpackage

// ===== hw/rtl/grid_sample_block_cache.sv =====
// grid_sample_block_cache: sampler over a 3D grid with a direct-mapped block cache.
// Depends on gsbc_pkg, gsbc_divider and assert_macros.svh.
//
// Usage: the input channel (in_valid/in_stall) carries query words (op 0) and
// fill words (op 1). The output channel (out_valid/out_stall) carries at most
// one result word per input word. Configuration is written through cfg_we,
// cfg_index and cfg_data; the user must write it only while the block is idle,
// and the block itself does not enforce this. A query runs three serial
// divisions in one shared restoring divider, which for each axis is set up,
// iterates and hands off. The row takes one 32x32 product, the hash and the
// fill offset two each, and the tag and store are then read from registered
// memories. Rejected points leave early. A mid-run fill word is stored from the
// idle state with no result; an out-of-order word or a failed fill gives its
// result straight from the idle state, a good last fill word after the store read.
// in_stall stays high while a word is in work or a result waits.
// While out_stall is high the result holds and no new word is taken.
// Reset clears the slot valid bits, the pending miss and all control state;
// the stores need no clearing. The default material is used only when
// MATERIALS_PRESENT is 0.
`include "assert_macros.svh"
module grid_sample_block_cache
    import gsbc_pkg::*;
#(
    parameter int CACHE_SLOTS = 64,
    parameter int BLOCK_SAMPLES = 64,
    parameter int MATERIALS_PRESENT = 1
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        op,
    input  logic signed [63:0] point_x,
    input  logic signed [63:0] point_y,
    input  logic signed [63:0] point_z,
    input  logic [31:0] fill_density_bits,
    input  logic [15:0] fill_material,
    input  logic        fill_last,
    input  logic        fill_error,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [31:0] density_bits,
    output logic [15:0] material,
    output logic [63:0] fill_offset,
    output logic [6:0]  fill_count
);
    localparam int SW = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;
    localparam int LW = (BLOCK_SAMPLES > 1) ? $clog2(BLOCK_SAMPLES) : 1;
    localparam int DEPTH = CACHE_SLOTS * BLOCK_SAMPLES;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(BLOCK_SAMPLES + 2);
    localparam logic [63:0] BS64 = 64'(BLOCK_SAMPLES);
    localparam logic [63:0] CS64 = 64'(CACHE_SLOTS);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DIV = 4'd1;
    localparam logic [3:0] S_ROW = 4'd2;
    localparam logic [3:0] S_ROW2 = 4'd3;
    localparam logic [3:0] S_HASH = 4'd4;
    localparam logic [3:0] S_HASH2 = 4'd5;
    localparam logic [3:0] S_LOOK = 4'd6;
    localparam logic [3:0] S_OFF = 4'd7;
    localparam logic [3:0] S_OFF2 = 4'd8;
    localparam logic [3:0] S_READ = 4'd9;
    localparam logic [3:0] S_EMIT = 4'd10;
    localparam logic [3:0] S_HASH_HI = 4'd11;
    localparam logic [3:0] S_OFF_HI = 4'd12;

    logic [63:0] origin_x_reg, origin_y_reg, origin_z_reg;
    logic [62:0] spacing_reg;
    logic [31:0] size_x_reg, size_y_reg, size_z_reg;
    logic [15:0] def_mat_reg;

    logic [3:0] state_reg;
    logic [1:0] axis_reg;
    logic [63:0] px_reg, py_reg, pz_reg;
    logic [63:0] ix_reg, iy_reg, iz_reg;
    logic [63:0] row_reg, acc_reg;
    logic [SW-1:0] slot_reg;
    logic [LW-1:0] local_reg;
    logic [31:0] block_reg;
    logic [6:0] count_reg;

    logic [CACHE_SLOTS-1:0] slot_valid_reg;
    logic [63:0] slot_row_mem [CACHE_SLOTS];
    logic [31:0] slot_block_mem [CACHE_SLOTS];
    logic [6:0] slot_count_mem [CACHE_SLOTS];
    logic [31:0] dens_mem [DEPTH];
    logic [15:0] mat_mem [DEPTH];
    logic [63:0] rd_row;
    logic [31:0] rd_block;
    logic [6:0] rd_count;
    logic [31:0] rd_dens;
    logic [15:0] rd_mat;

    logic miss_pending_reg;
    logic [SW-1:0] pend_slot_reg;
    logic [LW-1:0] pend_local_reg;
    logic [6:0] pend_count_reg;
    logic [CW-1:0] fill_idx_reg;

    logic out_valid_reg;
    logic [1:0] status_reg;
    logic [31:0] dens_out_reg;
    logic [15:0] mat_out_reg;
    logic [63:0] off_out_reg;
    logic [6:0] cnt_out_reg;

    div_req_t div_req;
    div_rsp_t div_rsp;

    gsbc_divider u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

    logic accept;
    assign in_stall = (state_reg != S_IDLE) || out_valid_reg;
    assign accept = in_valid && !in_stall;

    // axis operand selection for the shared divider and range check
    logic [63:0] ax_p, ax_o;
    logic [31:0] ax_size;
    logic [64:0] ax_delta;
    always_comb
    begin
        case (axis_reg)
            2'd0:
            begin
                ax_p = px_reg; ax_o = origin_x_reg; ax_size = size_x_reg;
            end
            2'd1:
            begin
                ax_p = py_reg; ax_o = origin_y_reg; ax_size = size_y_reg;
            end
            default:
            begin
                ax_p = pz_reg; ax_o = origin_z_reg; ax_size = size_z_reg;
            end
        endcase
        ax_delta = {ax_p[63], ax_p} - {ax_o[63], ax_o};
    end

    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic [63:0] bstart;
    logic [63:0] cnt_calc;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic fill_store;
    assign bstart = 64'(block_reg) * BS64;
    assign cnt_calc = (64'(size_x_reg) - bstart > BS64) ? BS64 : 64'(size_x_reg) - bstart;
    assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};
    assign wr_addr = AW'(pend_slot_reg) * AW'(BLOCK_SAMPLES) + AW'(fill_idx_reg);

    // one 32x32 product per cycle; 64-bit wrapping products take a low and a high step
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_ROW: begin mul_a = iz_reg[31:0]; mul_b = size_y_reg; end
            S_HASH: begin mul_a = row_reg[31:0]; mul_b = SLOT_HASH_MUL[31:0]; end
            S_HASH_HI: begin mul_a = row_reg[63:32]; mul_b = SLOT_HASH_MUL[31:0]; end
            S_OFF: begin mul_a = row_reg[31:0]; mul_b = size_x_reg; end
            S_OFF_HI: begin mul_a = row_reg[63:32]; mul_b = size_x_reg; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    logic [SW-1:0] look_slot;
    logic [LW-1:0] rd_local;
    always_comb
    begin
        look_slot = slot_reg;
        rd_local = local_reg;
        if (state_reg == S_IDLE)
        begin
            look_slot = pend_slot_reg;
            rd_local = pend_local_reg;
        end
        rd_addr = AW'(look_slot) * AW'(BLOCK_SAMPLES) + AW'(rd_local);
    end

    assign fill_store = accept && op && miss_pending_reg && !fill_error
        && (fill_idx_reg < CW'(pend_count_reg))
        && (fill_idx_reg < CW'(BLOCK_SAMPLES));

    // div request driven in S_DIV while the start flag is set: set on accept for the first axis, on done for later axes
    always_comb
    begin
        div_req.start = 1'b0;
        div_req.dividend = ax_delta;
        div_req.divisor = spacing_reg;
        if (state_reg == S_DIV && axis_reg != 2'd3 && acc_reg[0])
            div_req.start = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        rd_row <= slot_row_mem[look_slot];
        rd_block <= slot_block_mem[look_slot];
        rd_count <= slot_count_mem[look_slot];
        rd_dens <= dens_mem[rd_addr];
        rd_mat <= mat_mem[rd_addr];
        if (fill_store)
        begin
            dens_mem[wr_addr] <= fill_density_bits;
            mat_mem[wr_addr] <= fill_material;
        end
        if (state_reg == S_OFF2)
        begin
            slot_row_mem[slot_reg] <= row_reg;
            slot_block_mem[slot_reg] <= block_reg;
            slot_count_mem[slot_reg] <= count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0; origin_y_reg <= '0; origin_z_reg <= '0;
            spacing_reg <= 63'd1;
            size_x_reg <= 32'd1; size_y_reg <= 32'd1; size_z_reg <= 32'd1;
            def_mat_reg <= '0;
            state_reg <= S_IDLE;
            axis_reg <= '0;
            acc_reg <= '0;
            px_reg <= '0; py_reg <= '0; pz_reg <= '0;
            ix_reg <= '0; iy_reg <= '0; iz_reg <= '0;
            row_reg <= '0;
            slot_reg <= '0;
            local_reg <= '0;
            block_reg <= '0;
            count_reg <= '0;
            slot_valid_reg <= '0;
            miss_pending_reg <= 1'b0;
            pend_slot_reg <= '0;
            pend_local_reg <= '0;
            pend_count_reg <= '0;
            fill_idx_reg <= '0;
            out_valid_reg <= 1'b0;
            status_reg <= ST_SAMPLE;
            dens_out_reg <= '0;
            mat_out_reg <= '0;
            off_out_reg <= '0;
            cnt_out_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ORIGIN_X: origin_x_reg <= cfg_data;
                    CFG_ORIGIN_Y: origin_y_reg <= cfg_data;
                    CFG_ORIGIN_Z: origin_z_reg <= cfg_data;
                    CFG_SPACING: spacing_reg <= cfg_data[62:0];
                    CFG_SIZE_X: size_x_reg <= cfg_data[31:0];
                    CFG_SIZE_Y: size_y_reg <= cfg_data[31:0];
                    CFG_SIZE_Z: size_z_reg <= cfg_data[31:0];
                    CFG_DEF_MAT: def_mat_reg <= cfg_data[15:0];
                    default: ;
                endcase
            end
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        dens_out_reg <= '0; mat_out_reg <= '0;
                        off_out_reg <= '0; cnt_out_reg <= '0;
                        if (!op)
                        begin
                            if (miss_pending_reg)
                            begin
                                status_reg <= ST_ORDER;
                                out_valid_reg <= 1'b1;
                            end
                            else
                            begin
                                px_reg <= point_x; py_reg <= point_y; pz_reg <= point_z;
                                axis_reg <= 2'd0;
                                acc_reg <= 64'd1; // start flag
                                state_reg <= S_DIV;
                            end
                        end
                        else if (!miss_pending_reg)
                        begin
                            status_reg <= ST_ORDER;
                            out_valid_reg <= 1'b1;
                        end
                        else if (fill_error)
                        begin
                            miss_pending_reg <= 1'b0;
                            status_reg <= ST_NO_SAMPLE;
                            out_valid_reg <= 1'b1;
                        end
                        else
                        begin
                            if (fill_idx_reg <= CW'(pend_count_reg))
                                fill_idx_reg <= fill_idx_reg + CW'(1);
                            if (fill_last)
                            begin
                                miss_pending_reg <= 1'b0;
                                slot_reg <= pend_slot_reg;
                                local_reg <= pend_local_reg;
                                // run is good only if this word brings the total to the count
                                if (fill_idx_reg + CW'(1) != CW'(pend_count_reg))
                                begin
                                    status_reg <= ST_NO_SAMPLE;
                                    out_valid_reg <= 1'b1;
                                end
                                else
                                begin
                                    slot_valid_reg[pend_slot_reg] <= 1'b1;
                                    state_reg <= S_READ;
                                end
                            end
                        end
                    end
                end
                S_DIV:
                begin
                    if (acc_reg[0])
                    begin
                        acc_reg <= '0;
                        if (ax_delta[64] || spacing_reg == '0)
                        begin
                            status_reg <= ST_NO_SAMPLE;
                            out_valid_reg <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                    end
                    else if (div_rsp.done)
                    begin
                        if (!div_rsp.rem_zero || div_rsp.quotient >= 65'(ax_size))
                        begin
                            status_reg <= ST_NO_SAMPLE;
                            out_valid_reg <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            case (axis_reg)
                                2'd0: ix_reg <= div_rsp.quotient[63:0];
                                2'd1: iy_reg <= div_rsp.quotient[63:0];
                                default: iz_reg <= div_rsp.quotient[63:0];
                            endcase
                            if (axis_reg == 2'd2)
                                state_reg <= S_ROW;
                            else
                            begin
                                axis_reg <= axis_reg + 2'd1;
                                acc_reg <= 64'd1;
                            end
                        end
                    end
                end
                S_ROW:
                begin
                    acc_reg <= mul_p;
                    state_reg <= S_ROW2;
                end
                S_ROW2:
                begin
                    row_reg <= acc_reg + iy_reg;
                    block_reg <= 32'(ix_reg / BS64);
                    local_reg <= LW'(ix_reg % BS64);
                    state_reg <= S_HASH;
                end
                S_HASH:
                begin
                    acc_reg <= mul_p;
                    state_reg <= S_HASH_HI;
                end
                S_HASH_HI:
                begin
                    acc_reg <= acc_reg + {mul_p[31:0], 32'd0};
                    state_reg <= S_HASH2;
                end
                S_HASH2:
                begin
                    slot_reg <= SW'((acc_reg + 64'(block_reg)) % CS64);
                    state_reg <= S_READ;
                    axis_reg <= 2'd3; // marks lookup pass
                end
                S_READ:
                    state_reg <= (axis_reg == 2'd3) ? S_LOOK : S_EMIT;
                S_LOOK:
                begin
                    axis_reg <= 2'd0;
                    if (slot_valid_reg[slot_reg] && rd_row == row_reg && rd_block == block_reg)
                        state_reg <= S_EMIT;
                    else
                    begin
                        count_reg <= cnt_calc[6:0];
                        slot_valid_reg[slot_reg] <= 1'b0;
                        state_reg <= S_OFF;
                    end
                end
                S_OFF:
                begin
                    acc_reg <= mul_p;
                    state_reg <= S_OFF_HI;
                end
                S_OFF_HI:
                begin
                    acc_reg <= acc_reg + {mul_p[31:0], 32'd0};
                    state_reg <= S_OFF2;
                end
                S_OFF2:
                begin
                    miss_pending_reg <= 1'b1;
                    pend_slot_reg <= slot_reg;
                    pend_local_reg <= local_reg;
                    pend_count_reg <= count_reg;
                    fill_idx_reg <= '0;
                    status_reg <= ST_FILL_REQ;
                    off_out_reg <= acc_reg + bstart;
                    cnt_out_reg <= count_reg;
                    out_valid_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                S_EMIT:
                begin
                    if (7'(local_reg) >= rd_count || 64'(local_reg) >= BS64)
                        status_reg <= ST_NO_SAMPLE;
                    else
                    begin
                        status_reg <= ST_SAMPLE;
                        dens_out_reg <= rd_dens;
                        mat_out_reg <= (MATERIALS_PRESENT != 0) ? rd_mat : def_mat_reg;
                    end
                    out_valid_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign status = status_reg;
    assign density_bits = dens_out_reg;
    assign material = mat_out_reg;
    assign fill_offset = off_out_reg;
    assign fill_count = cnt_out_reg;

    `ASSERT_IMP(a_busy_stall, clk, rst_n, state_reg != S_IDLE, in_stall,
        "taken while busy")
    `ASSERT_NEXT(a_miss_req, clk, rst_n, state_reg == S_OFF2,
        miss_pending_reg && out_valid_reg && status_reg == ST_FILL_REQ,
        "miss without request")
    `ASSERT_IMP(a_req_fields, clk, rst_n, out_valid_reg && status_reg != ST_FILL_REQ,
        cnt_out_reg == 7'd0 && off_out_reg == 64'd0, "request fields leak")
endmodule

// ===== hw/rtl/gsbc_divider.sv =====
// gsbc_divider: restoring divider, one quotient bit a cycle over a 65-bit dividend.
// Depends on gsbc_pkg.
`include "assert_macros.svh"
module gsbc_divider
    import gsbc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);
    logic [64:0] quo_reg, quo_next;
    logic [63:0] rem_reg, rem_next;
    logic [62:0] dsr_reg, dsr_next;
    logic [6:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next;
    logic done_reg, done_next;
    logic [64:0] trial;

    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        dsr_next = dsr_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = {rem_reg, quo_reg[64]} - {2'b00, dsr_reg};
        if (req.start)
        begin
            quo_next = req.dividend;
            rem_next = '0;
            dsr_next = req.divisor;
            cnt_next = 7'd65;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[64])
            begin
                rem_next = trial[63:0];
                quo_next = {quo_reg[63:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[62:0], quo_reg[64]};
                quo_next = {quo_reg[63:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quotient = quo_reg;
    assign rsp.rem_zero = (rem_reg == '0);

    `ASSERT_NEXT(a_done_pulse, clk, rst_n, done_reg, !done_reg, "divider done held")
    `ASSERT_IMP(a_busy_cnt, clk, rst_n, busy_reg, cnt_reg != 7'd0, "busy with zero count")
    `ASSERT_IMP(a_done_idle, clk, rst_n, done_reg, !busy_reg, "done while busy")
endmodule

// ===== tb/sv/tb_top.sv =====
// tb_top: self-checking testbench for grid_sample_block_cache.
// Holds its own cache predictor in a small scoreboard class and drives queries and fill runs.
// Depends on gsbc_pkg and the grid_sample_block_cache RTL.
`timescale 1ns / 100ps

module tb_top
    import gsbc_pkg::*;
;
    localparam int SLOTS = 64;
    localparam int BLK = 64;
    localparam logic [63:0] MAX63 = 64'h7fff_ffff_ffff_ffff;

    typedef enum int {FILL_GOOD, FILL_ERR, FILL_SHORT, FILL_LONG} fill_mode_t;

    typedef struct {
        bit          op;
        logic [63:0] px;
        logic [63:0] py;
        logic [63:0] pz;
        logic [31:0] dens;
        logic [15:0] mat;
        bit          last;
        bit          err;
    } word_t;

    typedef struct {
        logic [1:0]  status;
        logic [31:0] dens;
        logic [15:0] mat;
        logic [63:0] off;
        logic [6:0]  cnt;
    } result_t;

    class sample_scoreboard;
        logic [63:0] org_x, org_y, org_z, spacing;
        logic [31:0] size_x, size_y, size_z;
        logic [15:0] def_mat;
        bit          slot_valid [SLOTS];
        logic [63:0] slot_row [SLOTS];
        logic [31:0] slot_block [SLOTS];
        int unsigned slot_count [SLOTS];
        logic [31:0] dens_mem [SLOTS*BLK];
        logic [15:0] mat_mem [SLOTS*BLK];
        bit          miss_pending;
        int unsigned pend_slot, pend_local, fill_idx;
        result_t     expected_q [$];
        int          errors;

        function void clear();
            org_x = 0; org_y = 0; org_z = 0; spacing = 1;
            size_x = 1; size_y = 1; size_z = 1; def_mat = 0;
            foreach (slot_valid[i]) slot_valid[i] = 0;
            miss_pending = 0; pend_slot = 0; pend_local = 0; fill_idx = 0;
            errors = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [63:0] v);
            case (idx)
                CFG_ORIGIN_X: org_x = v;
                CFG_ORIGIN_Y: org_y = v;
                CFG_ORIGIN_Z: org_z = v;
                CFG_SPACING:  spacing = v & MAX63;
                CFG_SIZE_X:   size_x = v[31:0];
                CFG_SIZE_Y:   size_y = v[31:0];
                CFG_SIZE_Z:   size_z = v[31:0];
                CFG_DEF_MAT:  def_mat = v[15:0];
                default: ;
            endcase
        endfunction

        function bit axis(logic [63:0] p, logic [63:0] o, logic [31:0] sz,
                          output logic [63:0] idx);
            logic [63:0] d;
            idx = 0;
            if ($signed(p) < $signed(o)) return 0;
            if (spacing == 0) return 0;
            d = p - o;
            if (d % spacing != 0) return 0;
            d = d / spacing;
            if (d >= {32'd0, sz}) return 0;
            idx = d;
            return 1;
        endfunction

        function result_t sample_at(int unsigned slot, int unsigned loc);
            result_t r;
            r = '{default: '0};
            if (loc >= slot_count[slot] || loc >= BLK) begin
                r.status = ST_NO_SAMPLE;
                return r;
            end
            r.status = ST_SAMPLE;
            r.dens = dens_mem[slot*BLK + loc];
            r.mat = mat_mem[slot*BLK + loc];
            return r;
        endfunction

        function void note_word(word_t w);
            result_t r;
            logic [63:0] x, y, z, row, start, cnt, h;
            logic [31:0] blk;
            int unsigned slot, loc;
            r = '{default: '0};
            if (!w.op) begin
                if (miss_pending) r.status = ST_ORDER;
                else if (!axis(w.px, org_x, size_x, x) || !axis(w.py, org_y, size_y, y) ||
                         !axis(w.pz, org_z, size_z, z)) r.status = ST_NO_SAMPLE;
                else begin
                    row = z * {32'd0, size_y} + y;
                    blk = 32'(x / 64'(BLK));
                    loc = 32'(x % 64'(BLK));
                    h = row * SLOT_HASH_MUL + {32'd0, blk};
                    slot = 32'(h % 64'(SLOTS));
                    if (slot_valid[slot] && slot_row[slot] == row && slot_block[slot] == blk)
                        r = sample_at(slot, loc);
                    else begin
                        start = {32'd0, blk} * 64'(BLK);
                        cnt = {32'd0, size_x} - start;
                        if (cnt > 64'(BLK)) cnt = 64'(BLK);
                        slot_valid[slot] = 0;
                        slot_row[slot] = row;
                        slot_block[slot] = blk;
                        slot_count[slot] = 32'(cnt);
                        miss_pending = 1;
                        pend_slot = slot;
                        pend_local = loc;
                        fill_idx = 0;
                        r.status = ST_FILL_REQ;
                        r.off = row * {32'd0, size_x} + start;
                        r.cnt = cnt[6:0];
                    end
                end
            end else begin
                if (!miss_pending) r.status = ST_ORDER;
                else if (w.err) begin
                    miss_pending = 0;
                    r.status = ST_NO_SAMPLE;
                end else begin
                    slot = pend_slot;
                    if (fill_idx < slot_count[slot] && fill_idx < BLK) begin
                        dens_mem[slot*BLK + fill_idx] = w.dens;
                        mat_mem[slot*BLK + fill_idx] = w.mat;
                    end
                    if (fill_idx <= slot_count[slot]) fill_idx++;
                    if (!w.last) return;   // mid-run word: no result
                    miss_pending = 0;
                    if (fill_idx != slot_count[slot]) r.status = ST_NO_SAMPLE;
                    else begin
                        slot_valid[slot] = 1;
                        r = sample_at(slot, pend_local);
                    end
                end
            end
            expected_q.push_back(r);
        endfunction

        function void check_result(result_t a);
            result_t e;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result status %0d", $time, a.status);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (a.status !== e.status) begin
                $display("%0t: status exp %0d act %0d", $time, e.status, a.status); errors++;
            end
            if (a.dens !== e.dens) begin
                $display("%0t: density exp %h act %h", $time, e.dens, a.dens); errors++;
            end
            if (a.mat !== e.mat) begin
                $display("%0t: material exp %h act %h", $time, e.mat, a.mat); errors++;
            end
            if (a.off !== e.off) begin
                $display("%0t: fill_offset exp %h act %h", $time, e.off, a.off); errors++;
            end
            if (a.cnt !== e.cnt) begin
                $display("%0t: fill_count exp %0d act %0d", $time, e.cnt, a.cnt); errors++;
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_we = 0;
    logic [2:0] cfg_index = 0;
    logic [63:0] cfg_data = 0;
    logic in_valid = 0;
    logic in_stall;
    logic op = 0;
    logic signed [63:0] point_x = 0, point_y = 0, point_z = 0;
    logic [31:0] fill_density_bits = 0;
    logic [15:0] fill_material = 0;
    logic fill_last = 0, fill_error = 0;
    logic out_valid;
    logic out_stall = 0;
    logic [1:0] status;
    logic [31:0] density_bits;
    logic [15:0] material;
    logic [63:0] fill_offset;
    logic [6:0] fill_count;

    sample_scoreboard sb = new();
    int n_words = 0;
    bit quiet = 0;
    int stall_left = 0;

    grid_sample_block_cache i_dut (.*);

    always #1 clk = ~clk;

    initial
    begin
        #4_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

    always @(negedge clk)
    begin
        if (!quiet && stall_left == 0 && $urandom_range(0, 9) == 0)
            stall_left = $urandom_range(1, 18);
        out_stall <= (stall_left != 0);
        if (stall_left != 0) stall_left--;
    end

    always @(posedge clk)
    begin
        result_t r;
        if (rst_n && out_valid && !out_stall) begin
            r.status = status; r.dens = density_bits; r.mat = material;
            r.off = fill_offset; r.cnt = fill_count;
            sb.check_result(r);
        end
    end

    task automatic send_word(word_t w);
        int gap;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 18);
            @(negedge clk) in_valid <= 0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1; op <= w.op;
        point_x <= w.px; point_y <= w.py; point_z <= w.pz;
        fill_density_bits <= w.dens; fill_material <= w.mat;
        fill_last <= w.last; fill_error <= w.err;
        do @(posedge clk); while (in_stall);
        sb.note_word(w);
        n_words++;
    endtask

    // all results in, then allow a mid-run fill word to drain
    task automatic wait_idle();
        @(negedge clk) in_valid <= 0;
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic cfg_write(logic [2:0] idx, logic [63:0] v);
        wait_idle();
        @(negedge clk);
        cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
        @(negedge clk) cfg_we <= 0;
        sb.write_reg(idx, v);
    endtask

    task automatic grid_setup(logic [63:0] ox, logic [63:0] oy, logic [63:0] oz,
                              logic [63:0] sp, logic [31:0] sx, logic [31:0] sy,
                              logic [31:0] sz, logic [15:0] dm);
        cfg_write(CFG_ORIGIN_X, ox);
        cfg_write(CFG_ORIGIN_Y, oy);
        cfg_write(CFG_ORIGIN_Z, oz);
        cfg_write(CFG_SPACING, sp);
        cfg_write(CFG_SIZE_X, {32'd0, sx});
        cfg_write(CFG_SIZE_Y, {32'd0, sy});
        cfg_write(CFG_SIZE_Z, {32'd0, sz});
        cfg_write(CFG_DEF_MAT, {48'd0, dm});
    endtask

    function automatic word_t rand_word(bit o);
        word_t w;
        w.op = o;
        w.px = {$urandom, $urandom}; w.py = {$urandom, $urandom}; w.pz = {$urandom, $urandom};
        w.dens = $urandom; w.mat = 16'($urandom);
        w.last = 1'($urandom_range(0, 1)); w.err = 0;
        return w;
    endfunction

    task automatic query_at(logic [63:0] ix, logic [63:0] iy, logic [63:0] iz);
        word_t w;
        w = rand_word(0);
        w.px = sb.org_x + ix * sb.spacing;
        w.py = sb.org_y + iy * sb.spacing;
        w.pz = sb.org_z + iz * sb.spacing;
        send_word(w);
    endtask

    task automatic fill_run(fill_mode_t mode);
        int cnt, n, err_at;
        word_t w;
        if (!sb.miss_pending) return;
        cnt = int'(sb.slot_count[sb.pend_slot]);
        if (mode == FILL_SHORT && cnt == 1) mode = FILL_LONG;
        n = cnt;
        err_at = -1;
        if (mode == FILL_SHORT) n = int'($urandom_range(1, cnt - 1));
        if (mode == FILL_LONG) n = cnt + int'($urandom_range(1, 3));
        if (mode == FILL_ERR) err_at = int'($urandom_range(0, cnt - 1));
        for (int i = 0; i < n; i++) begin
            w = rand_word(1);
            w.last = (i == n - 1);
            w.err = (i == err_at);
            if (w.err) w.last = 1'($urandom_range(0, 1));
            send_word(w);
            if (w.err) break;
        end
    endtask

    function automatic fill_mode_t pick_mode();
        int r;
        r = int'($urandom_range(0, 19));
        if (r < 16) return FILL_GOOD;
        if (r < 18) return FILL_ERR;
        return (r == 18) ? FILL_SHORT : FILL_LONG;
    endfunction

    function automatic logic [63:0] pick_idx(logic [31:0] sz, int lim);
        if (sz == 0) return 64'($urandom_range(0, 3));
        return 64'($urandom_range(0, (sz - 1 < lim) ? sz - 1 : lim));
    endfunction

    initial
    begin
        word_t w;
        int r;
        sb.clear();
        repeat (4) @(posedge clk);
        @(negedge clk) rst_n <= 1;

        // directed: defaults, hit, stray fill, extreme points
        query_at(0, 0, 0);
        fill_run(FILL_GOOD);
        query_at(0, 0, 0);
        send_word(rand_word(1));
        w = rand_word(0);
        w.px = 64'h7fff_ffff_ffff_ffff; w.py = 64'h8000_0000_0000_0000; w.pz = 0;
        send_word(w);
        w.px = 64'h8000_0000_0000_0000; w.py = 64'h7fff_ffff_ffff_ffff; w.pz = '1;
        send_word(w);

        grid_setup(64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_fff0, -64'sd5,
                   3, 100, 2, 2, 16'hffff);
        query_at(70, 1, 1);
        query_at(0, 0, 0);      // query while a miss is open
        fill_run(FILL_GOOD);
        query_at(0, 0, 0);
        fill_run(FILL_ERR);
        query_at(0, 0, 0);
        fill_run(FILL_SHORT);
        query_at(0, 0, 0);
        fill_run(FILL_LONG);
        query_at(0, 0, 0);
        fill_run(FILL_GOOD);
        w = rand_word(0);
        w.px = sb.org_x + 1; w.py = sb.org_y; w.pz = sb.org_z;   // off the lattice
        send_word(w);
        // wider grid: block 1 still holds 36 samples, local 40 is past them
        cfg_write(CFG_SIZE_X, 200);
        query_at(104, 1, 1);
        cfg_write(CFG_SPACING, 0);
        query_at(0, 0, 0);
        cfg_write(CFG_SPACING, 3);
        cfg_write(CFG_SIZE_Z, 0);
        query_at(0, 0, 0);
        grid_setup(0, 0, 0, MAX63, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 0);
        query_at(1, 0, 0);
        fill_run(FILL_GOOD);

        // random phases
        for (int ph = 0; n_words < 520; ph++) begin
            case (ph % 4)
                0: grid_setup({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                              64'($urandom_range(1, 9)), $urandom_range(1, 140),
                              $urandom_range(1, 4), $urandom_range(1, 4), 16'($urandom));
                1: grid_setup({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                              {$urandom, $urandom} & MAX63, $urandom_range(1, 70),
                              $urandom_range(1, 3), $urandom_range(1, 3), 16'($urandom));
                2: grid_setup({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                              1, 32'hffff_ffff, $urandom, $urandom, 16'($urandom));
                default: grid_setup(-64'sd1000, 64'sd7, 0, 64'($urandom_range(1, 1000)),
                                    $urandom_range(1, 20), $urandom_range(1, 5),
                                    $urandom_range(1, 2), 16'($urandom));
            endcase
            if (ph == 2) wait_idle();
            for (int k = 0; k < 40 && n_words < 520; k++) begin
                quiet = (n_words > 440);
                r = int'($urandom_range(0, 19));
                if (r < 15) begin
                    query_at(pick_idx(sb.size_x, (ph % 4 == 2) ? 130 : 150),
                             pick_idx(sb.size_y, 2), pick_idx(sb.size_z, 2));
                    if (sb.miss_pending && $urandom_range(0, 9) == 0)
                        send_word(rand_word(0));
                    fill_run(pick_mode());
                end else if (r < 18) begin
                    send_word(rand_word(0));
                    fill_run(pick_mode());
                end else
                    send_word(rand_word(1));
            end
        end

        wait_idle();
        repeat (50) @(posedge clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end
endmodule

// ===== grid_sample_block_cache.f =====
+incdir+hw/rtl
hw/rtl/gsbc_pkg.sv
hw/rtl/gsbc_divider.sv
hw/rtl/grid_sample_block_cache.sv
tb/sv/tb_top.sv
